/* rtl/core/ising_metropolis_spin_update_top_assert.svh */
// Assertion macros for the spin update block.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_TOP_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IMS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ims_pkg.sv */
package ims_pkg;

    localparam int SIDE   = 32;
    localparam int SITES  = SIDE * SIDE;
    localparam int ADDR_W = $clog2(SIDE);

    localparam int SITE_W = 5;
    localparam int DRAW_W = 16;
    localparam int LIM_W  = 17;
    localparam int EN_W   = 14;
    localparam int MG_W   = 12;

    // totals after a clear
    localparam logic [EN_W-1:0] EN_RESET = EN_W'(-(4 * SITES));
    localparam logic [MG_W-1:0] MG_RESET = MG_W'(SITES);

    // energy step per flip is 2*dE = 8*n_same - 16
    localparam int DE_BASE    = -8;
    localparam int EN_FLIP_OFS = -2 * DE_BASE;

    // item kinds (tuser)
    localparam logic MODE_CLEAR  = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // config register indexes
    localparam int   CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM_DE4 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM_DE8 = 1'b1;

    typedef struct packed {
        logic [5:0]        pad;
        logic [DRAW_W-1:0] random_draw;
        logic [SITE_W-1:0] site_col;
        logic [SITE_W-1:0] site_row;
    } in_word_t;

    typedef struct packed {
        logic [2:0]             pad;
        logic                   rejected;
        logic signed [MG_W-1:0] magnet_total;
        logic signed [EN_W-1:0] energy_total;
        logic                   spin_now;
        logic                   flipped;
    } out_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [SIDE-1:0]   wr_data;
        logic              clr;
    } mem_req_t;

endpackage

/* rtl/core/ims_lattice_mem.sv */
module ims_lattice_mem (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ims_pkg::mem_req_t              mem_req,
    output logic [ims_pkg::SIDE-1:0]       rd_data_a,
    output logic [ims_pkg::SIDE-1:0]       rd_data_b
);
    import ims_pkg::*;

    // one row of spins per entry, bit = column
    logic [SIDE-1:0] row_mem [SIDE];
    logic [SIDE-1:0] row_vld_reg;
    logic [SIDE-1:0] data_a_reg;
    logic [SIDE-1:0] data_b_reg;
    logic            vld_a_reg;
    logic            vld_b_reg;

    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            data_a_reg <= row_mem[mem_req.rd_addr_a];
            data_b_reg <= row_mem[mem_req.rd_addr_b];
            vld_a_reg  <= row_vld_reg[mem_req.rd_addr_a];
            vld_b_reg  <= row_vld_reg[mem_req.rd_addr_b];
        end
        if (mem_req.wr_en) begin
            row_mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    // a row never written since the last clear reads as all +1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (mem_req.clr) begin
            row_vld_reg <= '0;
        end else if (mem_req.wr_en) begin
            row_vld_reg[mem_req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data_a = vld_a_reg ? data_a_reg : '1;
    assign rd_data_b = vld_b_reg ? data_b_reg : '1;

endmodule

/* rtl/core/ims_core.sv */
module ims_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ims_pkg::in_word_t                 in_word,
    input  logic                              in_mode,
    input  logic                              cfg_we,
    input  logic [ims_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ims_pkg::LIM_W-1:0]         cfg_wdata,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ims_pkg::out_word_t                out_word,
    output ims_pkg::mem_req_t                 mem_req,
    input  logic [ims_pkg::SIDE-1:0]          rd_data_a,
    input  logic [ims_pkg::SIDE-1:0]          rd_data_b
);
    import ims_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CTR  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [DRAW_W-1:0] draw_reg, draw_next;
    logic              up_bit_reg, up_bit_next;
    logic              dn_bit_reg, dn_bit_next;
    logic [EN_W-1:0]   en_reg, en_next;
    logic [MG_W-1:0]   mg_reg, mg_next;
    logic              res_flip_reg, res_flip_next;
    logic              res_spin_reg, res_spin_next;
    logic              res_rej_reg, res_rej_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;
    logic [LIM_W-1:0]  lim4_reg;
    logic [LIM_W-1:0]  lim8_reg;

    logic [ADDR_W-1:0] in_row, in_col, up_addr, dn_addr;
    logic              out_of_range;
    logic [ADDR_W-1:0] lf_col, rt_col;
    logic              spin_s;
    logic [3:0]        same_vec;
    logic [2:0]        n_same;
    logic              accept;

    assign in_row  = ADDR_W'(in_word.site_row);
    assign in_col  = ADDR_W'(in_word.site_col);
    assign out_of_range = (32'(in_word.site_row) >= SIDE) || (32'(in_word.site_col) >= SIDE);
    assign up_addr = (in_row == '0) ? ADDR_W'(SIDE - 1) : in_row - ADDR_W'(1);
    assign dn_addr = (in_row == ADDR_W'(SIDE - 1)) ? '0 : in_row + ADDR_W'(1);

    // EVAL: center row is on port a
    assign lf_col   = (col_reg == '0) ? ADDR_W'(SIDE - 1) : col_reg - ADDR_W'(1);
    assign rt_col   = (col_reg == ADDR_W'(SIDE - 1)) ? '0 : col_reg + ADDR_W'(1);
    assign spin_s   = rd_data_a[col_reg];
    assign same_vec = ~({up_bit_reg, dn_bit_reg, rd_data_a[lf_col], rd_data_a[rt_col]}
                        ^ {4{spin_s}});
    assign n_same   = 3'($countones(same_vec));
    // dE = 4*n_same - 8
    assign accept   = (n_same <= 3'd2)
                   || ((n_same == 3'd3) && ({1'b0, draw_reg} <= lim4_reg))
                   || ((n_same == 3'd4) && ({1'b0, draw_reg} <= lim8_reg));

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        draw_next      = draw_reg;
        up_bit_next    = up_bit_reg;
        dn_bit_next    = dn_bit_reg;
        en_next        = en_reg;
        mg_next        = mg_reg;
        res_flip_next  = res_flip_reg;
        res_spin_next  = res_spin_reg;
        res_rej_next   = res_rej_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    row_next  = in_row;
                    col_next  = in_col;
                    draw_next = in_word.random_draw;
                    if (in_mode == MODE_CLEAR) begin
                        mem_req.clr   = 1'b1;
                        en_next       = EN_RESET;
                        mg_next       = MG_RESET;
                        res_flip_next = 1'b0;
                        res_spin_next = 1'b1;
                        res_rej_next  = 1'b0;
                        state_next    = ST_OUT;
                    end else if (out_of_range) begin
                        res_flip_next = 1'b0;
                        res_spin_next = 1'b0;
                        res_rej_next  = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        mem_req.rd_en     = 1'b1;
                        mem_req.rd_addr_a = up_addr;
                        mem_req.rd_addr_b = dn_addr;
                        state_next        = ST_CTR;
                    end
                end
            end
            ST_CTR: begin
                up_bit_next       = rd_data_a[col_reg];
                dn_bit_next       = rd_data_b[col_reg];
                mem_req.rd_en     = 1'b1;
                mem_req.rd_addr_a = row_reg;
                mem_req.rd_addr_b = row_reg;
                state_next        = ST_EVAL;
            end
            ST_EVAL: begin
                if (accept) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = row_reg;
                    mem_req.wr_data = rd_data_a ^ (SIDE'(1) << col_reg);
                    en_next = en_reg + EN_W'({n_same, 3'b000}) - EN_W'(EN_FLIP_OFS);
                    mg_next = spin_s ? mg_reg - MG_W'(2) : mg_reg + MG_W'(2);
                end
                res_flip_next = accept;
                res_spin_next = spin_s ^ accept;
                res_rej_next  = 1'b0;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next             = 1'b1;
                    out_word_next.pad          = '0;
                    out_word_next.flipped      = res_flip_reg;
                    out_word_next.spin_now     = res_spin_reg;
                    out_word_next.energy_total = en_reg;
                    out_word_next.magnet_total = mg_reg;
                    out_word_next.rejected     = res_rej_reg;
                    state_next                 = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            en_reg        <= EN_RESET;
            mg_reg        <= MG_RESET;
            lim4_reg      <= '0;
            lim8_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            en_reg        <= en_next;
            mg_reg        <= mg_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_LIM_DE4: lim4_reg <= cfg_wdata;
                    CFG_LIM_DE8: lim8_reg <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        draw_reg     <= draw_next;
        up_bit_reg   <= up_bit_next;
        dn_bit_reg   <= dn_bit_next;
        res_flip_reg <= res_flip_next;
        res_spin_reg <= res_spin_next;
        res_rej_reg  <= res_rej_next;
        out_word_reg <= out_word_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* rtl/core/ising_metropolis_spin_update_top.sv */
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: row, col, draw; s_tuser: mode
// m_        out  m_tvalid/m_tready  m_tdata: flipped, spin, energy, magnet, rejected
// cfg_      in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// Sequence: an update word holds the block while it issues the neighbor row reads,
//   reads the center row, evaluates and writes back, and loads the output. A clear
//   or a rejected site goes straight to loading the output. The spin RAM's
//   registered read sets this sequence.
// One word is in work at a time, so a following word never reads a stale row.
// Reset: synchronous, active low. Row valid flags clear at once; no clearing pass.
// Stalls: the result sits in an output register; a full output register holds
//   the next result in the last stage and keeps s_tready low.
module ising_metropolis_spin_update_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // [4:0] site_row, [9:5] site_col,
                                                      // [25:10] random_draw, zero pad
    input  logic                            s_tuser,  // [0] mode (0 clear, 1 update)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // [0] flipped, [1] spin_now,
                                                      // [15:2] energy_total,
                                                      // [27:16] magnet_total,
                                                      // [28] rejected, zero pad
    input  logic                            cfg_we,
    input  logic [ims_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ims_pkg::LIM_W-1:0]       cfg_wdata
);
    import ims_pkg::*;

    in_word_t        s_word;
    out_word_t       m_word;
    mem_req_t        mem_req;
    logic [SIDE-1:0] rd_data_a;
    logic [SIDE-1:0] rd_data_b;

    assign s_word  = in_word_t'(s_tdata);
    assign m_tdata = 32'(m_word);

    // control: sequencing, acceptance test, running totals, output register
    ims_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_word),
        .in_mode   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_word),
        .mem_req   (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // spin lattice, one row per word, two read ports
    ims_lattice_mem u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mem_req   (mem_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

`include "ising_metropolis_spin_update_top_assert.svh"

    // one word in work at a time
`IMS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready,
    !s_tready, "word accepted while busy")
    // a rejected site never reports a flip or a spin
`IMS_ASSERT_IMPLIES(a_rej_clean, aclk, aresetn, m_tvalid && m_word.rejected,
    !m_word.flipped && !m_word.spin_now, "rejected result with flip or spin set")
    // energy total moves in steps of 8 from a multiple of 4
`IMS_ASSERT_IMPLIES(a_energy_align, aclk, aresetn, m_tvalid,
    m_word.energy_total[1:0] == 2'b00, "energy total misaligned")
    // magnetization keeps the parity of the site count
`IMS_ASSERT_IMPLIES(a_magnet_parity, aclk, aresetn, m_tvalid,
    m_word.magnet_total[0] == MG_RESET[0], "magnetization parity broken")

endmodule
